// ----- hw/rtl/prsu_pkg.sv -----
// ----------------------------------------------------------------------------
// prsu_pkg
// Shared types and constants of the packed raw sample unpacker.
// ----------------------------------------------------------------------------
package prsu_pkg;

  localparam int MAX_WIDTH_DEF   = 8192;
  localparam int MAX_HEIGHT_DEF  = 16384;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam int LANES = 4;

  localparam logic [1:0] FMT_RAW10 = 2'd0;
  localparam logic [1:0] FMT_RAW12 = 2'd1;
  localparam logic [1:0] FMT_RAW16 = 2'd2;

  localparam logic [1:0] CFG_PIXEL_FORMAT  = 2'd0;
  localparam logic [1:0] CFG_ROW_WIDTH     = 2'd1;
  localparam logic [1:0] CFG_ROW_STRIDE    = 2'd2;
  localparam logic [1:0] CFG_SAMPLE_STRIDE = 2'd3;

  localparam logic [1:0]  RST_PIXEL_FORMAT  = FMT_RAW10;
  localparam logic [13:0] RST_ROW_WIDTH     = 14'd4096;
  localparam logic [15:0] RST_ROW_STRIDE    = 16'd5120;
  localparam logic [3:0]  RST_SAMPLE_STRIDE = 4'd2;

  typedef struct packed {
    logic [1:0]  pixel_format;
    logic [13:0] row_width;
    logic [15:0] row_stride_bytes;
    logic [3:0]  sample_stride_bytes;
  } cfg_t;

  // One decoded group: up to four samples of one row, lanes 0..count-1 valid.
  typedef struct packed {
    logic [LANES-1:0][15:0] value;
    logic [12:0]            x0;
    logic [13:0]            y;
    logic [LANES-1:0]       row_end;
    logic [2:0]             count;
  } grp_t;

  typedef struct packed {
    logic empty;
    logic full;
  } qstat_t;

endpackage

// ----- hw/rtl/prsu_front.sv -----
// ----------------------------------------------------------------------------
// prsu_front
// Byte parser: tracks row, group and column position, collects group bytes
// and hands each completed group with its sample lanes to the queue.
// ----------------------------------------------------------------------------
module prsu_front #(
  parameter int MAX_WIDTH  = prsu_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = prsu_pkg::MAX_HEIGHT_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  prsu_pkg::cfg_t cfg,
  input  logic           accept,
  input  logic [7:0]     data_byte,
  input  logic           frame_start,
  output logic           grp_push,
  output prsu_pkg::grp_t grp
);
  import prsu_pkg::*;

  localparam int WCAP  = (MAX_WIDTH < 16383) ? MAX_WIDTH : 16383;
  localparam int ROW_W = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
  localparam int COL_W = 19;
  localparam int PL_W  = 18;

  logic [15:0]      bir_r, bir_nxt;
  logic [2:0]       big_r, big_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [7:0]       gb_r [LANES];

  logic [15:0]      bir;
  logic [2:0]       g;
  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;
  logic [13:0]      w;
  logic [3:0]       ps;
  logic [PL_W-1:0]  pl;
  logic [PL_W-1:0]  quad;
  logic [PL_W-1:0]  pair;
  logic             active;
  logic             gb_we;
  logic [1:0]       gb_idx;
  logic [2:0]       nl;
  logic [LANES-1:0] lv;
  logic [2:0]       cnt;
  logic [3:0]       g_inc;
  logic [ROW_W+13:0] row_ext;

  always_comb begin
    bir = frame_start ? '0 : bir_r;
    g   = frame_start ? '0 : big_r;
    col = frame_start ? '0 : col_r;
    row = frame_start ? '0 : row_r;

    w = (cfg.row_width > 14'(WCAP)) ? 14'(WCAP) : cfg.row_width;
    if (cfg.sample_stride_bytes < 4'd2) begin
      ps = 4'd2;
    end else if (cfg.sample_stride_bytes > 4'd8) begin
      ps = 4'd8;
    end else begin
      ps = cfg.sample_stride_bytes;
    end

    quad = (PL_W'(w) + PL_W'(3)) >> 2;
    pair = (PL_W'(w) + PL_W'(1)) >> 1;
    unique case (cfg.pixel_format)
      FMT_RAW10: pl = (quad << 2) + quad;
      FMT_RAW12: pl = (pair << 1) + pair;
      FMT_RAW16: pl = PL_W'(w) * PL_W'(ps);
      default:   pl = '0;
    endcase
    active = PL_W'(bir) < pl;

    g_inc   = {1'b0, g} + 4'd1;
    big_nxt = g;
    col_nxt = col;
    gb_we   = 1'b0;
    gb_idx  = g[1:0];
    nl      = '0;
    for (int l = 0; l < LANES; l++) begin
      grp.value[l] = {6'b0, gb_r[l], data_byte[2*l +: 2]};
    end

    if (active) begin
      unique case (cfg.pixel_format)
        FMT_RAW10: begin
          if (g < 3'd4) begin
            gb_we   = 1'b1;
            big_nxt = g_inc[2:0];
          end else begin
            nl      = 3'd4;
            col_nxt = col + COL_W'(4);
            big_nxt = '0;
          end
        end
        FMT_RAW12: begin
          grp.value[0] = {4'b0, gb_r[0], data_byte[3:0]};
          grp.value[1] = {4'b0, gb_r[1], data_byte[7:4]};
          if (g < 3'd2) begin
            gb_we   = 1'b1;
            big_nxt = g_inc[2:0];
          end else begin
            nl      = 3'd2;
            col_nxt = col + COL_W'(2);
            big_nxt = '0;
          end
        end
        FMT_RAW16: begin
          grp.value[0] = {data_byte, gb_r[0]};
          gb_idx       = 2'd0;
          if (g == 3'd0) begin
            gb_we = 1'b1;
          end else if (g == 3'd1) begin
            nl      = 3'd1;
            col_nxt = col + COL_W'(1);
          end
          big_nxt = (g_inc >= ps) ? 3'd0 : g_inc[2:0];
        end
        default: begin
        end
      endcase
    end

    cnt = '0;
    for (int l = 0; l < LANES; l++) begin
      lv[l] = (3'(l) < nl) && ((col + COL_W'(l)) < COL_W'(w));
      grp.row_end[l] = (col + COL_W'(l)) == (COL_W'(w) - COL_W'(1));
      cnt = cnt + 3'(lv[l]);
    end

    row_ext   = {14'b0, row};
    grp.x0    = col[12:0];
    grp.y     = row_ext[13:0];
    grp.count = cnt;
    grp_push  = accept && (cnt != 3'd0);

    if (bir == (cfg.row_stride_bytes - 16'd1)) begin
      bir_nxt = '0;
      big_nxt = '0;
      col_nxt = '0;
      row_nxt = (row == ROW_W'(MAX_HEIGHT - 1)) ? '0 : row + ROW_W'(1);
    end else begin
      bir_nxt = bir + 16'd1;
      row_nxt = row;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bir_r <= '0;
      big_r <= '0;
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      bir_r <= bir_nxt;
      big_r <= big_nxt;
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && gb_we) begin
      gb_r[gb_idx] <= data_byte;
    end
  end

endmodule

// ----- hw/rtl/prsu_fifo.sv -----
// ----------------------------------------------------------------------------
// prsu_fifo
// Short group queue between parser and sample serializer.
// ----------------------------------------------------------------------------
module prsu_fifo #(
  parameter int DEPTH = prsu_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  prsu_pkg::grp_t             push_data,
  input  logic                       pop,
  output prsu_pkg::grp_t             pop_data,
  output prsu_pkg::qstat_t           stat,
  output logic [$clog2(DEPTH+1)-1:0] count
);
  import prsu_pkg::*;

  localparam int PTR_W = (DEPTH > 2) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  grp_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_r, rd_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  always_comb begin
    stat.empty = (cnt_r == '0);
    stat.full  = (cnt_r == CNT_W'(DEPTH));
    do_push    = push && !stat.full;
    do_pop     = pop && !stat.empty;
    cnt_nxt    = cnt_r + CNT_W'(do_push) - CNT_W'(do_pop);
    pop_data   = mem_r[rd_r];
    count      = cnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wr_r <= (wr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_r <= (rd_r == PTR_W'(DEPTH - 1)) ? '0 : rd_r + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_data;
    end
  end

endmodule

// ----- hw/rtl/prsu_back.sv -----
// ----------------------------------------------------------------------------
// prsu_back
// Sample serializer: walks the lanes of one group at a time into the
// output register and takes the next group as its last lane goes out.
// ----------------------------------------------------------------------------
module prsu_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  prsu_pkg::grp_t q_data,
  output logic           q_pop,
  output logic           busy,
  input  logic           out_pop,
  output logic           out_empty,
  output logic [15:0]    out_sample_value,
  output logic [12:0]    out_pixel_x,
  output logic [13:0]    out_pixel_y,
  output logic           out_row_end,
  output logic           out_last
);
  import prsu_pkg::*;

  grp_t        cur_r;
  logic        cur_v_r;
  logic [1:0]  idx_r;
  logic        out_v_r;
  logic [15:0] val_r;
  logic [12:0] x_r;
  logic [13:0] y_r;
  logic        rend_r;
  logic        last_r;

  logic out_free, last_lane, emit, load;

  always_comb begin
    out_free  = !out_v_r || out_pop;
    last_lane = ({1'b0, idx_r} == (cur_r.count - 3'd1));
    emit      = cur_v_r && out_free;
    load      = !cur_v_r || (emit && last_lane);
    q_pop     = load && q_valid;
    busy      = cur_v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_v_r <= 1'b0;
      out_v_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      if (load) begin
        cur_v_r <= q_valid;
      end
      if (q_pop) begin
        idx_r <= '0;
      end else if (emit) begin
        idx_r <= idx_r + 2'd1;
      end
      if (emit) begin
        out_v_r <= 1'b1;
      end else if (out_pop) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_data;
    end
    if (emit) begin
      val_r  <= cur_r.value[idx_r];
      x_r    <= cur_r.x0 + 13'(idx_r);
      y_r    <= cur_r.y;
      rend_r <= cur_r.row_end[idx_r];
      last_r <= last_lane;
    end
  end

  assign out_empty        = !out_v_r;
  assign out_sample_value = val_r;
  assign out_pixel_x      = x_r;
  assign out_pixel_y      = y_r;
  assign out_row_end      = rend_r;
  assign out_last         = last_r;

endmodule

// ----- hw/rtl/packed_raw_sample_unpack_unit.sv -----
// ----------------------------------------------------------------------------
// packed_raw_sample_unpack_unit
// Unpacks a RAW10 / RAW12 / RAW16 byte stream into samples with position.
// ----------------------------------------------------------------------------
// Takes one frame byte per cycle whenever in_full is low and returns one
// sample per cycle on the output queue while it is popped. A byte that
// completes a group yields its samples (up to four for RAW10, two for RAW12,
// one for RAW16), which pass the queue, the serializer's group register and
// the output register, waiting while earlier groups are serialized. The
// serializer emits one sample a cycle while the output is popped. Up to
// QUEUE_DEPTH finished groups wait between parser and serializer; in_full
// rises only when that queue is full. No start-up sweep after reset.
// Configuration writes are always taken (cfg_ready stays high) and must
// happen while the block is idle.
// ----------------------------------------------------------------------------
module packed_raw_sample_unpack_unit #(
  parameter int MAX_WIDTH   = prsu_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT  = prsu_pkg::MAX_HEIGHT_DEF,
  parameter int QUEUE_DEPTH = prsu_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_data_byte,
  input  logic        in_frame_start,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [15:0] out_sample_value,
  output logic [12:0] out_pixel_x,
  output logic [13:0] out_pixel_y,
  output logic        out_row_end,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import prsu_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cfg_t             cfg_r;
  logic             accept;
  logic             grp_push;
  grp_t             grp_in;
  grp_t             grp_out;
  qstat_t           q_stat;
  logic [CNT_W-1:0] q_count;
  logic             q_pop;
  logic             back_busy;

  assign cfg_ready = 1'b1;
  assign in_full   = q_stat.full;
  assign accept    = in_push && !in_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pixel_format        <= RST_PIXEL_FORMAT;
      cfg_r.row_width           <= RST_ROW_WIDTH;
      cfg_r.row_stride_bytes    <= RST_ROW_STRIDE;
      cfg_r.sample_stride_bytes <= RST_SAMPLE_STRIDE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_PIXEL_FORMAT:  cfg_r.pixel_format        <= cfg_data[1:0];
        CFG_ROW_WIDTH:     cfg_r.row_width           <= cfg_data[13:0];
        CFG_ROW_STRIDE:    cfg_r.row_stride_bytes    <= cfg_data;
        CFG_SAMPLE_STRIDE: cfg_r.sample_stride_bytes <= cfg_data[3:0];
      endcase
    end
  end

  prsu_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .accept      (accept),
    .data_byte   (in_data_byte),
    .frame_start (in_frame_start),
    .grp_push    (grp_push),
    .grp         (grp_in)
  );

  prsu_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (grp_push),
    .push_data (grp_in),
    .pop       (q_pop),
    .pop_data  (grp_out),
    .stat      (q_stat),
    .count     (q_count)
  );

  prsu_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (!q_stat.empty),
    .q_data           (grp_out),
    .q_pop            (q_pop),
    .busy             (back_busy),
    .out_pop          (out_pop),
    .out_empty        (out_empty),
    .out_sample_value (out_sample_value),
    .out_pixel_x      (out_pixel_x),
    .out_pixel_y      (out_pixel_y),
    .out_row_end      (out_row_end),
    .out_last         (out_last)
  );

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= CNT_W'(QUEUE_DEPTH))
    else $error("group queue count exceeds depth");

  a_group_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_last) |-> back_busy)
    else $error("non-final sample shown without rest of group pending");

  a_group_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_last && out_pop) |=> !out_empty)
    else $error("bubble inside a group transaction");

endmodule
